>>> rtl/core/aam_pkg.sv
// ----------------------------------------------------------------------------
// aam_pkg
// Shared constants and helpers for the axis arg-min block.
// ----------------------------------------------------------------------------
package aam_pkg;

    localparam int MAX_INNER_DEF = 1024;
    localparam int MAX_AXIS_DEF  = 65535;

    localparam int AXIS_W  = 16;
    localparam int INNER_W = 11;
    localparam int OUTER_W = 16;
    localparam int ELEM_W  = 32;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INNER  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUTER  = 2'd3;

    // ieee less-than on raw bits, half selects binary16 in the low bits
    function automatic logic fp_less(input logic [31:0] a, input logic [31:0] b,
                                     input logic half);
        logic [31:0] sgn;
        logic [31:0] all;
        logic [31:0] inf;
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] ka;
        logic [31:0] kb;
        sgn = half ? 32'h0000_8000 : 32'h8000_0000;
        all = half ? 32'h0000_FFFF : 32'hFFFF_FFFF;
        inf = half ? 32'h0000_7C00 : 32'h7F80_0000;
        ma  = a & (all ^ sgn);
        mb  = b & (all ^ sgn);
        ka  = ((a & sgn) != 32'd0) ? (all ^ a) : (a | sgn);
        kb  = ((b & sgn) != 32'd0) ? (all ^ b) : (b | sgn);
        if (ma > inf || mb > inf) begin
            fp_less = 1'b0;
        end else if (ma == 32'd0 && mb == 32'd0) begin
            fp_less = 1'b0;
        end else begin
            fp_less = ka < kb;
        end
    endfunction

endpackage

>>> rtl/core/axis_argmin_with_value.sv
// ----------------------------------------------------------------------------
// axis_argmin_with_value
// Streaming arg-min along one tensor axis, keeping value and index.
// ----------------------------------------------------------------------------
// Elements enter on s_ (valid/ready) in memory order outer, axis, inner, one
// item per cycle while s_ready is high. A ram of MAX_INNER entries holds the
// running minimum and its axis index for each inner position; each item reads
// its entry, compares and writes back in the next cycle, forwarding the last
// write when the next item hits the same entry (inner count of one).
// During the last axis row each item yields one result on m_ via stage 1 and
// the result register; tensor_done marks the last result of the tensor.
// Throughput is one item per cycle while s_ready is high. When the receiver
// stalls, a result register and one skid entry absorb the items in flight
// and s_ready drops until the skid entry drains.
// Reset clears the counters and loads the default sizes; the ram needs no
// clearing as each entry is overwritten at axis position zero, read value unused.
// A configuration write restarts the tensor at position zero.
// ----------------------------------------------------------------------------
module axis_argmin_with_value #(
    parameter int MAX_INNER = aam_pkg::MAX_INNER_DEF,
    parameter int MAX_AXIS  = aam_pkg::MAX_AXIS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [aam_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [aam_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [31:0]                   s_elem_bits,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [15:0]                   m_arg_pos,
    output logic [31:0]                   m_min_value,
    output logic                          m_tensor_done
);

    localparam int AW = $clog2(MAX_INNER > 1 ? MAX_INNER : 2);

    logic        step;
    logic        half;
    logic [AW-1:0] slot;
    logic        first;
    logic        last_axis;
    logic        last_all;
    logic [15:0] axis_idx;
    logic        busy;

    // stall input whenever the output side could overflow:
    // accept if the result register is free or being drained, or if no
    // item is in flight and the result was not already stalled
    logic out_full_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_full_reg <= 1'b0;
        end else begin
            out_full_reg <= m_valid && !m_ready;
        end
    end

    // with a stalled result a second in-flight item goes to the skid entry
    assign s_ready = !(m_valid && !m_ready && (busy || out_full_reg));
    assign step    = s_valid && s_ready;

    aam_ctrl #(.MAX_INNER(MAX_INNER), .MAX_AXIS(MAX_AXIS)) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (step),
        .half      (half),
        .slot      (slot),
        .first     (first),
        .last_axis (last_axis),
        .last_all  (last_all),
        .axis_idx  (axis_idx)
    );

    aam_update #(.MAX_INNER(MAX_INNER)) u_upd (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (step),
        .elem          (s_elem_bits),
        .half          (half),
        .slot          (slot),
        .first         (first),
        .last_axis     (last_axis),
        .last_all      (last_all),
        .axis_idx      (axis_idx),
        .busy          (busy),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_arg_pos     (m_arg_pos),
        .m_min_value   (m_min_value),
        .m_tensor_done (m_tensor_done)
    );

endmodule

>>> rtl/core/aam_ram.sv
// ----------------------------------------------------------------------------
// aam_ram
// Generic single-clock ram, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module aam_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> rtl/core/aam_ctrl.sv
// ----------------------------------------------------------------------------
// aam_ctrl
// Position counters and configuration registers; issues memory reads.
// ----------------------------------------------------------------------------
module aam_ctrl #(
    parameter int MAX_INNER = aam_pkg::MAX_INNER_DEF,
    parameter int MAX_AXIS  = aam_pkg::MAX_AXIS_DEF,
    localparam int AW = $clog2(MAX_INNER > 1 ? MAX_INNER : 2)
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [aam_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [aam_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           step,
    output logic                           half,
    output logic [AW-1:0]                  slot,
    output logic                           first,
    output logic                           last_axis,
    output logic                           last_all,
    output logic [aam_pkg::AXIS_W-1:0]     axis_idx
);

    localparam int IW = aam_pkg::INNER_W;
    localparam logic [16:0] MAX_INNER_C = 17'(MAX_INNER);
    localparam logic [16:0] MAX_AXIS_C  = 17'(MAX_AXIS);

    logic                        format_reg;
    logic [aam_pkg::AXIS_W-1:0]  axis_len_reg;
    logic [IW-1:0]               inner_cnt_reg;
    logic [aam_pkg::OUTER_W-1:0] outer_cnt_reg;
    logic [aam_pkg::AXIS_W-1:0]  axis_pos_reg;
    logic [AW:0]                 inner_pos_reg;
    logic [aam_pkg::OUTER_W-1:0] outer_pos_reg;

    logic [16:0] a_eff;
    logic [16:0] n_eff;
    logic [16:0] o_eff;
    logic [16:0] a_raw;
    logic [16:0] n_raw;
    logic        last_inner;

    // effective lengths: zero acts as one, axis and inner clipped to the limits
    always_comb begin
        a_raw = (axis_len_reg == '0) ? 17'd1 : 17'(axis_len_reg);
        n_raw = (inner_cnt_reg == '0) ? 17'd1 : 17'(inner_cnt_reg);
        a_eff = (a_raw > MAX_AXIS_C) ? MAX_AXIS_C : a_raw;
        n_eff = (n_raw > MAX_INNER_C) ? MAX_INNER_C : n_raw;
        o_eff = (outer_cnt_reg == '0) ? 17'd1 : 17'(outer_cnt_reg);
    end

    assign half       = format_reg;
    assign slot       = inner_pos_reg[AW-1:0];
    assign first      = (axis_pos_reg == '0);
    assign last_inner = (17'(inner_pos_reg) + 17'd1 >= n_eff);
    assign last_axis  = (17'(axis_pos_reg) + 17'd1 >= a_eff);
    assign last_all   = (17'(outer_pos_reg) + 17'd1 >= o_eff) && last_inner;
    assign axis_idx   = axis_pos_reg;

    // configuration and position counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            format_reg    <= 1'b0;
            axis_len_reg  <= 16'd1;
            inner_cnt_reg <= 11'd1;
            outer_cnt_reg <= 16'd1;
            axis_pos_reg  <= '0;
            inner_pos_reg <= '0;
            outer_pos_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                aam_pkg::REG_FORMAT: format_reg    <= cfg_data[0];
                aam_pkg::REG_AXIS:   axis_len_reg  <= cfg_data;
                aam_pkg::REG_INNER:  inner_cnt_reg <= cfg_data[IW-1:0];
                aam_pkg::REG_OUTER:  outer_cnt_reg <= cfg_data;
                default: ;
            endcase
            axis_pos_reg  <= '0;
            inner_pos_reg <= '0;
            outer_pos_reg <= '0;
        end else if (step) begin
            if (last_inner) begin
                inner_pos_reg <= '0;
                if (last_axis) begin
                    axis_pos_reg <= '0;
                    outer_pos_reg <= (17'(outer_pos_reg) + 17'd1 >= o_eff) ? '0
                                     : outer_pos_reg + 16'd1;
                end else begin
                    axis_pos_reg <= axis_pos_reg + 16'd1;
                end
            end else begin
                inner_pos_reg <= inner_pos_reg + 1'b1;
            end
        end
    end

endmodule

>>> rtl/core/aam_update.sv
// ----------------------------------------------------------------------------
// aam_update
// Read-modify-write of the running minimum, with forwarding, and result skid.
// ----------------------------------------------------------------------------
module aam_update #(
    parameter int MAX_INNER = aam_pkg::MAX_INNER_DEF,
    localparam int AW = $clog2(MAX_INNER > 1 ? MAX_INNER : 2)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        step,
    input  logic [31:0]                 elem,
    input  logic                        half,
    input  logic [AW-1:0]               slot,
    input  logic                        first,
    input  logic                        last_axis,
    input  logic                        last_all,
    input  logic [aam_pkg::AXIS_W-1:0]  axis_idx,
    output logic                        busy,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [15:0]                 m_arg_pos,
    output logic [31:0]                 m_min_value,
    output logic                        m_tensor_done
);

    localparam int DW = 48;

    // stage 1 holds the item while the ram read completes
    logic        s1_vld_reg;
    logic [31:0] s1_elem_reg;
    logic [AW-1:0] s1_slot_reg;
    logic        s1_first_reg;
    logic        s1_last_reg;
    logic        s1_done_reg;
    logic [15:0] s1_idx_reg;
    logic        s1_half_reg;

    // last write, kept for forwarding
    logic        wb_vld_reg;
    logic [AW-1:0] wb_slot_reg;
    logic [DW-1:0] wb_data_reg;

    logic [DW-1:0] rd_data;
    logic [DW-1:0] cur;
    logic [DW-1:0] upd;
    logic          wr_en;
    logic          take;

    // output register plus skid entry
    logic        o_vld_reg;
    logic [DW:0] o_data_reg;
    logic        k_vld_reg;
    logic [DW:0] k_data_reg;

    assign busy = s1_vld_reg;

    aam_ram #(.WIDTH(DW), .DEPTH(MAX_INNER)) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (s1_slot_reg),
        .wr_data (upd),
        .rd_addr (slot),
        .rd_data (rd_data)
    );

    // forward the previous write when it hit the same entry
    always_comb begin
        cur = (wb_vld_reg && wb_slot_reg == s1_slot_reg) ? wb_data_reg : rd_data;
        take = s1_first_reg || aam_pkg::fp_less(s1_elem_reg, cur[31:0], s1_half_reg);
        upd = take ? {s1_idx_reg, s1_elem_reg} : cur;
        wr_en = s1_vld_reg;
    end

    // pipeline registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            wb_vld_reg <= 1'b0;
        end else begin
            s1_vld_reg <= step;
            wb_vld_reg <= s1_vld_reg;
        end
        if (step) begin
            s1_elem_reg  <= half ? {16'd0, elem[15:0]} : elem;
            s1_slot_reg  <= slot;
            s1_first_reg <= first;
            s1_last_reg  <= last_axis;
            s1_done_reg  <= last_all && last_axis;
            s1_idx_reg   <= axis_idx;
            s1_half_reg  <= half;
        end
        if (s1_vld_reg) begin
            wb_slot_reg <= s1_slot_reg;
            wb_data_reg <= upd;
        end
    end

    // result output with skid entry
    logic push;
    assign push = s1_vld_reg && s1_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_vld_reg <= 1'b0;
            k_vld_reg <= 1'b0;
        end else begin
            if (!o_vld_reg || m_ready) begin
                if (k_vld_reg) begin
                    o_vld_reg  <= 1'b1;
                    o_data_reg <= k_data_reg;
                    k_vld_reg  <= push;
                    k_data_reg <= {s1_done_reg, upd};
                end else begin
                    o_vld_reg  <= push;
                    o_data_reg <= {s1_done_reg, upd};
                end
            end else if (push) begin
                k_vld_reg  <= 1'b1;
                k_data_reg <= {s1_done_reg, upd};
            end
        end
    end

    assign m_valid       = o_vld_reg;
    assign m_arg_pos     = o_data_reg[47:32];
    assign m_min_value   = o_data_reg[31:0];
    assign m_tensor_done = o_data_reg[DW];

endmodule
